>>> rtl/swz_pkg.sv
// ----------------------------------------------------------------------------
// swz_pkg
// Shared constants, types and codes of the sliding window z-score detector.
// ----------------------------------------------------------------------------
package swz_pkg;

  localparam int WINDOW_DEF      = 50;
  localparam int CHANNELS_DEF    = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CHAN_W     = 2;
  localparam int MEAN_OUT_W = 24;
  localparam int STD_OUT_W  = 23;
  localparam int Z_W        = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int FIFO_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_Z_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STD     = 4'd1;

  localparam logic [CFG_W-1:0]     Z_THRESHOLD_RST = 16'd768;
  localparam logic [CFG_W-1:0]     MIN_STD_RST     = 16'd3;
  localparam logic [STD_OUT_W-1:0] STD_MAX         = 23'h7fffff;
  localparam logic [Z_W-1:0]       Z_MAX           = 16'hffff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_ACC,
    ST_MUL,
    ST_MEANW,
    ST_VARS,
    ST_VARW,
    ST_SQW,
    ST_ZS,
    ST_ZW,
    ST_OUT
  } swz_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } swz_unit_stat_t;

endpackage

>>> rtl/swz_fifo.sv
// ----------------------------------------------------------------------------
// swz_fifo
// Small register queue, used between front and back and on the result side.
// ----------------------------------------------------------------------------
module swz_fifo import swz_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/swz_front.sv
// ----------------------------------------------------------------------------
// swz_front
// Accepts samples, drops those of channels that do not exist, queues the rest.
// ----------------------------------------------------------------------------
module swz_front import swz_pkg::*; #(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [CHAN_W-1:0]             in_channel,
  input  logic [SAMPLE_BITS-1:0]        in_sample,
  input  logic                          item_pop,
  output logic [CHAN_W+SAMPLE_BITS-1:0] item_data,
  output logic                          item_empty
);

  logic q_full, chan_ok;

  // samples of absent channels are taken and dropped
  assign chan_ok = (32'(in_channel) < CHANNELS);
  assign full    = q_full;

  swz_fifo #(
    .W     (CHAN_W + SAMPLE_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push && chan_ok),
    .wr_data ({in_channel, in_sample}),
    .full    (q_full),
    .rd_en   (item_pop),
    .rd_data (item_data),
    .empty   (item_empty)
  );

endmodule

>>> rtl/swz_div.sv
// ----------------------------------------------------------------------------
// swz_div
// Restoring divider, one quotient bit per cycle, variable step count.
// ----------------------------------------------------------------------------
module swz_div import swz_pkg::*; #(
  parameter int NUM_W  = 60,
  parameter int DEN_W  = 23,
  parameter int ITER_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ITER_W-1:0] iters,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output swz_unit_stat_t    stat,
  output logic [NUM_W-1:0]  q
);

  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r, rem_r;
  logic [ITER_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DEN_W:0]    rem_sh, rem_sub;
  logic              take;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign take    = (rem_sh >= {1'b0, den_r});

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign q         = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= (iters != '0);
        done_r <= (iters == '0);
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // align the used numerator bits to the top
      num_r <= num << (ITER_W'(NUM_W) - iters);
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], take};
      rem_r <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

>>> rtl/swz_isqrt.sv
// ----------------------------------------------------------------------------
// swz_isqrt
// Integer square root, floor, one root bit per cycle.
// ----------------------------------------------------------------------------
module swz_isqrt import swz_pkg::*; #(
  parameter int IN_W = 60
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [IN_W-1:0]        v,
  output swz_unit_stat_t         stat,
  output logic [(IN_W+1)/2-1:0]  root
);

  localparam int R_W   = (IN_W + 1) / 2;
  localparam int V_W   = 2 * R_W;
  localparam int CNT_W = $clog2(R_W + 1);

  logic [V_W-1:0]   v_r;
  logic [R_W+1:0]   rem_r;
  logic [R_W-1:0]   root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [R_W+3:0]   rem_sh, trial;
  logic             take;

  assign rem_sh = {rem_r, v_r[V_W-1 -: 2]};
  assign trial  = (R_W+4)'({root_r, 2'b01});
  assign take   = (rem_sh >= trial);

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(R_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= V_W'(v);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[V_W-3:0], 2'b00};
      rem_r  <= take ? (R_W+2)'(rem_sh - trial) : (R_W+2)'(rem_sh);
      root_r <= {root_r[R_W-2:0], take};
    end
  end

endmodule

>>> rtl/swz_back.sv
// ----------------------------------------------------------------------------
// swz_back
// Per-channel window update and statistics sequencer: ring, running sums,
// mean and variance divides, square root and z-score divide.
// ----------------------------------------------------------------------------
module swz_back import swz_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_empty,
  input  logic [CHAN_W+SAMPLE_BITS-1:0] item_data,
  output logic                          item_pop,
  input  logic [CFG_W-1:0]              z_threshold,
  input  logic [CFG_W-1:0]              min_std_dev,
  input  logic                          res_full,
  output logic                          res_push,
  output logic [CHAN_W+MEAN_OUT_W+STD_OUT_W+Z_W:0] res_data
);

  localparam int CNT_W    = $clog2(WINDOW + 1);
  localparam int POS_W    = $clog2(WINDOW);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH    = CHANNELS * WINDOW;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SUM_W    = SAMPLE_BITS + CNT_W;
  localparam int SQ_W     = 2 * SAMPLE_BITS + CNT_W - 1;
  localparam int SQR_W    = 2 * SAMPLE_BITS;
  localparam int P_W      = 2 * SUM_W;
  localparam int MN_W     = SUM_W + 8;
  localparam int VN_W     = P_W + 16;
  localparam int MEAN_W   = SAMPLE_BITS + 9;
  localparam int DEV_W    = SAMPLE_BITS + 10;
  localparam int ZN_W     = DEV_W + 8;
  localparam int NN_W     = 2 * CNT_W;
  localparam int DEN_W    = (NN_W > STD_OUT_W) ? NN_W : STD_OUT_W;
  localparam int ITER_W   = $clog2(VN_W + 1);
  localparam int R_W      = (VN_W + 1) / 2;

  // sample ring, one row of WINDOW entries per channel
  logic signed [SAMPLE_BITS-1:0] ring_r [DEPTH];

  // per-channel window state
  logic        [POS_W-1:0] wpos_r [CHANNELS];
  logic        [CNT_W-1:0] fill_r [CHANNELS];
  logic signed [SUM_W-1:0] sum_r  [CHANNELS];
  logic        [SQ_W-1:0]  sq_r   [CHANNELS];

  swz_state_t st_r, st_nxt;

  logic        [CHAN_W-1:0]      ch_r;
  logic        [CH_IDX_W-1:0]    idx_r;
  logic signed [SAMPLE_BITS-1:0] x_r, rd_r, old_r;
  logic        [POS_W-1:0]       pos_r;
  logic        [ADDR_W-1:0]      addr_r;
  logic                          was_full_r;
  logic        [SQR_W-1:0]       xsq_r;
  logic        [CNT_W-1:0]       n_r;
  logic signed [SUM_W-1:0]       s_r;
  logic        [SQ_W-1:0]        q_r;
  logic        [P_W-1:0]         prod1_r, prod2_r, d_r;
  logic        [NN_W-1:0]        nn_r;
  logic signed [MEAN_W-1:0]      mean_r;
  logic        [STD_OUT_W-1:0]   std_r;
  logic        [Z_W-1:0]         z_r;

  logic        [CHAN_W-1:0]      hd_ch;
  logic        [CH_IDX_W-1:0]    hd_idx;
  logic        [ADDR_W-1:0]      rd_addr;
  logic                          go;
  logic signed [SQR_W-1:0]       xsq_s, oldsq_s;
  logic signed [P_W-1:0]         ss_s;
  logic        [SUM_W-1:0]       mag;
  logic signed [DEV_W-1:0]       diff;
  logic        [DEV_W-1:0]       dev;
  logic        [MEAN_W-1:0]      mean_mag;

  logic                          div_start;
  logic        [ITER_W-1:0]      div_iters;
  logic        [VN_W-1:0]        div_num;
  logic        [DEN_W-1:0]       div_den;
  swz_unit_stat_t                div_stat;
  logic        [VN_W-1:0]        div_q;
  logic                          sqrt_start;
  swz_unit_stat_t                sqrt_stat;
  logic        [R_W-1:0]         sqrt_root;
  logic                          var_pos, z_on;

  assign hd_ch   = item_data[CHAN_W+SAMPLE_BITS-1 -: CHAN_W];
  assign hd_idx  = CH_IDX_W'(hd_ch);
  assign rd_addr = ADDR_W'(int'(hd_idx) * WINDOW + int'(wpos_r[hd_idx]));
  assign go      = !item_empty && !res_full;

  assign xsq_s    = x_r * x_r;
  assign oldsq_s  = old_r * old_r;
  assign ss_s     = s_r * s_r;
  assign mag      = s_r[SUM_W-1] ? SUM_W'(-s_r) : SUM_W'(s_r);
  assign mean_mag = div_q[MEAN_W-1:0];
  assign diff     = (DEV_W'(x_r) <<< 8) - DEV_W'(mean_r);
  assign dev      = diff[DEV_W-1] ? DEV_W'(-diff) : DEV_W'(diff);
  assign var_pos  = (n_r >= CNT_W'(2)) && (d_r != '0);
  assign z_on     = (std_r > STD_OUT_W'(min_std_dev));

  swz_div #(
    .NUM_W  (VN_W),
    .DEN_W  (DEN_W),
    .ITER_W (ITER_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .iters (div_iters),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .q     (div_q)
  );

  swz_isqrt #(
    .IN_W (VN_W)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .v     (div_q),
    .stat  (sqrt_stat),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    item_pop   = 1'b0;
    res_push   = 1'b0;
    div_start  = 1'b0;
    div_iters  = ITER_W'(MN_W);
    div_num    = VN_W'({mag, 8'b0}) + VN_W'(n_r >> 1);
    div_den    = DEN_W'(n_r);
    sqrt_start = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (go) begin
          item_pop = 1'b1;
          st_nxt   = ST_SQR;
        end
      end
      ST_SQR:   st_nxt = ST_ACC;
      ST_ACC:   st_nxt = ST_MUL;
      ST_MUL: begin
        // rounded mean magnitude: (|sum| * 256 + n / 2) / n
        div_start = 1'b1;
        st_nxt    = ST_MEANW;
      end
      ST_MEANW: begin
        if (div_stat.done) begin
          st_nxt = ST_VARS;
        end
      end
      ST_VARS: begin
        div_iters = ITER_W'(VN_W);
        div_num   = {d_r, 16'b0};
        div_den   = DEN_W'(nn_r);
        if (var_pos) begin
          div_start = 1'b1;
          st_nxt    = ST_VARW;
        end else begin
          st_nxt = ST_ZS;
        end
      end
      ST_VARW: begin
        if (div_stat.done) begin
          sqrt_start = 1'b1;
          st_nxt     = ST_SQW;
        end
      end
      ST_SQW: begin
        if (sqrt_stat.done) begin
          st_nxt = ST_ZS;
        end
      end
      ST_ZS: begin
        div_iters = ITER_W'(ZN_W);
        div_num   = VN_W'({dev, 8'b0});
        div_den   = DEN_W'(std_r);
        if (z_on) begin
          div_start = 1'b1;
          st_nxt    = ST_ZW;
        end else begin
          st_nxt = ST_OUT;
        end
      end
      ST_ZW: begin
        if (div_stat.done) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        res_push = 1'b1;
        st_nxt   = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // per-channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wpos_r[i] <= '0;
        fill_r[i] <= '0;
        sum_r[i]  <= '0;
        sq_r[i]   <= '0;
      end
    end else if (st_r == ST_ACC) begin
      wpos_r[idx_r] <= (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + 1'b1;
      fill_r[idx_r] <= was_full_r ? fill_r[idx_r] : fill_r[idx_r] + 1'b1;
      sum_r[idx_r]  <= sum_r[idx_r] - SUM_W'(old_r) + SUM_W'(x_r);
      sq_r[idx_r]   <= sq_r[idx_r] - SQ_W'(SQR_W'(oldsq_s)) + SQ_W'(xsq_r);
    end
  end

  // ring: the oldest entry is read before the new sample overwrites it
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE) begin
      rd_r <= ring_r[rd_addr];
    end
    if (st_r == ST_SQR) begin
      ring_r[addr_r] <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (go) begin
          ch_r       <= hd_ch;
          idx_r      <= hd_idx;
          x_r        <= item_data[SAMPLE_BITS-1:0];
          pos_r      <= wpos_r[hd_idx];
          addr_r     <= rd_addr;
          was_full_r <= (fill_r[hd_idx] >= CNT_W'(WINDOW));
        end
      end
      ST_SQR: begin
        old_r <= was_full_r ? rd_r : '0;
        xsq_r <= SQR_W'(xsq_s);
      end
      ST_ACC: begin
        n_r     <= was_full_r ? fill_r[idx_r] : fill_r[idx_r] + 1'b1;
        s_r     <= sum_r[idx_r] - SUM_W'(old_r) + SUM_W'(x_r);
        q_r     <= sq_r[idx_r] - SQ_W'(SQR_W'(oldsq_s)) + SQ_W'(xsq_r);
      end
      ST_MUL: begin
        prod1_r <= P_W'(n_r) * P_W'(q_r);
        prod2_r <= P_W'(ss_s);
        nn_r    <= NN_W'(n_r) * NN_W'(n_r);
        std_r   <= '0;
        z_r     <= '0;
      end
      ST_MEANW: begin
        if (div_stat.done) begin
          mean_r <= s_r[SUM_W-1] ? MEAN_W'(-mean_mag) : MEAN_W'(mean_mag);
          d_r    <= prod1_r - prod2_r;
        end
      end
      ST_SQW: begin
        if (sqrt_stat.done) begin
          std_r <= (sqrt_root > R_W'(STD_MAX)) ? STD_MAX : sqrt_root[STD_OUT_W-1:0];
        end
      end
      ST_ZW: begin
        if (div_stat.done) begin
          z_r <= (div_q > VN_W'(Z_MAX)) ? Z_MAX : div_q[Z_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign res_data = {ch_r, MEAN_OUT_W'(mean_r), std_r, z_r, (z_r > z_threshold)};

`ifndef NO_ASSERTIONS
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_OUT |-> !res_full)
    else $error("result queue full at result transfer");

  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_MUL |-> (n_r != '0) && (n_r <= CNT_W'(WINDOW)))
    else $error("window count out of range");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy && !sqrt_stat.busy)
    else $error("divider started while busy");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_IDLE |-> !div_stat.busy && !sqrt_stat.busy)
    else $error("arithmetic unit busy while idle");
`endif

endmodule

>>> rtl/sliding_window_zscore_detector.sv
// ----------------------------------------------------------------------------
// sliding_window_zscore_detector
// Per-channel sliding window mean, standard deviation and z-score anomaly flag.
// ----------------------------------------------------------------------------
// Samples enter through a two-entry queue and are handled one at a time: ring
// and sum update, then a shared divider producing one quotient bit per cycle
// runs the mean divide (SAMPLE_BITS+clog2(WINDOW+1)+8 steps), the variance
// divide (2*(SAMPLE_BITS+clog2(WINDOW+1))+16 steps) and the z-score divide
// (SAMPLE_BITS+18 steps), and a square root unit takes half the variance
// divide steps; each unit reports its end with a registered done flag. The
// variance divide and root are skipped when the standard deviation is zero,
// the z-score divide when it is not above min_std_dev. Results wait in a
// two-entry queue, so a new sample is taken while a result waits to be popped.
// Samples tagged with a channel at or above CHANNELS are taken and dropped.
module sliding_window_zscore_detector import swz_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic [CHAN_W-1:0]      in_channel,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  output logic                   empty,
  input  logic                   pop,
  output logic [CHAN_W-1:0]      out_channel_out,
  output logic [MEAN_OUT_W-1:0]  out_window_mean,
  output logic [STD_OUT_W-1:0]   out_window_std,
  output logic [Z_W-1:0]         out_z_score,
  output logic                   out_anomaly,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int ITEM_W = CHAN_W + SAMPLE_BITS;
  localparam int RES_W  = CHAN_W + MEAN_OUT_W + STD_OUT_W + Z_W + 1;

  logic [CFG_W-1:0]  z_threshold_r, min_std_r;
  logic [ITEM_W-1:0] item_data;
  logic              item_empty, item_pop;
  logic              res_full, res_push;
  logic [RES_W-1:0]  res_data, res_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_threshold_r <= Z_THRESHOLD_RST;
      min_std_r     <= MIN_STD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_Z_THRESHOLD: z_threshold_r <= cfg_data;
        CFG_MIN_STD:     min_std_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  swz_front #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_channel (in_channel),
    .in_sample  (in_sample),
    .item_pop   (item_pop),
    .item_data  (item_data),
    .item_empty (item_empty)
  );

  swz_back #(
    .WINDOW      (WINDOW),
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_empty  (item_empty),
    .item_data   (item_data),
    .item_pop    (item_pop),
    .z_threshold (z_threshold_r),
    .min_std_dev (min_std_r),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_data    (res_data)
  );

  swz_fifo #(
    .W     (RES_W),
    .DEPTH (FIFO_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign {out_channel_out, out_window_mean, out_window_std, out_z_score, out_anomaly} = res_head;

endmodule
